// ===== hw/rtl/set_assoc_cache_tag_lru_top_assert.svh =====
// Assertion macros shared by the cache tag store modules.
// Define ASSERT_OFF to compile the checks away.
`ifndef SET_ASSOC_CACHE_TAG_LRU_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LRU_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle check, held off during reset.
`define SACT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Implication checked in the cycle after the trigger, held off during reset.
`define SACT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SACT_ASSERT(lbl, expr, msg)
`define SACT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// sact_pkg
// Types and constants shared by the cache tag store controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package sact_pkg;

  localparam int TAG_W    = 32;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int WAY_OUT_W = 3;
  localparam int OFF_MAX  = 12;
  localparam int WAY_OUT_MAX = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd5;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;
  localparam logic [CFG_W-1:0] WAYS_RST        = 4'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sact_ram.sv =====
// ----------------------------------------------------------------------------
// sact_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sact_ctrl.sv =====
// ----------------------------------------------------------------------------
// sact_ctrl
// Sequencer: clearing pass after reset, then accept, look up and update.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_cache_tag_lru_top_assert.svh"
module sact_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output sact_pkg::cmd_t     cmd,
  input  wire sact_pkg::sts_t sts
);
  import sact_pkg::*;

  state_t state_r, state_nxt;

  // hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // decode next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SACT_ASSERT_NEXT(a_accept_lookup, start && !busy, state_r == ST_LOOKUP, "accept not followed by lookup")
  `SACT_ASSERT_NEXT(a_lookup_idle, state_r == ST_LOOKUP, state_r == ST_IDLE, "lookup not single cycle")
  `SACT_ASSERT(a_clear_excl, !(cmd.clear && (cmd.load || cmd.update)), "transaction during clear")

endmodule
`default_nettype wire

// ===== hw/rtl/sact_dp.sv =====
// ----------------------------------------------------------------------------
// sact_dp
// Datapath: configuration, address split, set RAMs, hit and victim search,
// age update and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_cache_tag_lru_top_assert.svh"
module sact_dp #(
  parameter int SET_COUNT    = 256,
  parameter int WAY_COUNT    = 8,
  parameter int AGE_BITS     = 7,
  parameter int ADDRESS_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire sact_pkg::cmd_t                   cmd,
  output sact_pkg::sts_t                        sts,
  input  wire logic                             cfg_we,
  input  wire logic [sact_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sact_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                             in_action,
  input  wire logic [31:0]                      in_address,
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic [sact_pkg::WAY_OUT_W-1:0]        out_way_used,
  output logic                                  out_writeback,
  output logic [31:0]                           out_writeback_address
);
  import sact_pkg::*;

  localparam int SET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int MAX_IDX = $clog2(SET_COUNT + 1) - 1;
  localparam int WAY_LIM = (WAY_COUNT < WAY_OUT_MAX) ? WAY_COUNT : WAY_OUT_MAX;
  localparam int MW      = AGE_BITS + 2;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic [31:0] ADDR_MASK = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic [CFG_W-1:0] off_r, idx_r, ways_r;
  logic [CFG_W-1:0] off_eff, idx_eff, ways_eff;
  logic [SET_W-1:0] clr_cnt_r;
  logic [31:0]      addr_m, set_full, tag_in;
  logic [4:0]       sh_in;
  logic [SET_W-1:0] set_in, set_r;
  logic [31:0]      tag_r;
  logic [4:0]       sh_r;
  logic [CFG_W-1:0] offs_r;
  logic [CFG_W-1:0] ways_ld_r;
  logic             act_r;

  logic [WAY_COUNT*TAG_W-1:0] tag_row, tag_row_new;
  logic [WAY_COUNT*MW-1:0]    meta_row, meta_row_new, meta_wdata;
  logic [SET_W-1:0]           meta_waddr;
  logic                       meta_we;

  logic [TAG_W-1:0]    tag_a [WAY_COUNT];
  logic [AGE_BITS-1:0] age_a [WAY_COUNT];
  logic                vld_a [WAY_COUNT];
  logic                drt_a [WAY_COUNT];
  logic                hit_c, inv_c, wb_c;
  logic [WAY_W-1:0]    hit_way, inv_way, old_way, victim;
  logic [31:0]         wb_addr_c;

  logic             out_valid_r, out_hit_r, out_wb_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic [31:0]      out_wba_r;

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= OFFSET_BITS_RST;
      idx_r  <= INDEX_BITS_RST;
      ways_r <= WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: off_r  <= cfg_data;
        CFG_INDEX_BITS:  idx_r  <= cfg_data;
        CFG_WAYS_IN_USE: ways_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the configuration to what the store supports
  always_comb begin
    off_eff  = (off_r > CFG_W'(OFF_MAX)) ? CFG_W'(OFF_MAX) : off_r;
    idx_eff  = (idx_r > CFG_W'(MAX_IDX)) ? CFG_W'(MAX_IDX) : idx_r;
    if (ways_r == '0) begin
      ways_eff = CFG_W'(1);
    end else if (ways_r > CFG_W'(WAY_LIM)) begin
      ways_eff = CFG_W'(WAY_LIM);
    end else begin
      ways_eff = ways_r;
    end
  end

  // split the address into set and tag
  always_comb begin
    addr_m   = in_address & ADDR_MASK;
    sh_in    = 5'(off_eff) + 5'(idx_eff);
    set_full = (addr_m >> off_eff) & ((32'd1 << idx_eff) - 32'd1);
    set_in   = set_full[SET_W-1:0];
    tag_in   = addr_m >> sh_in;
  end

  // advance the clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end
  assign sts.clear_last = (clr_cnt_r == SET_W'(SET_COUNT - 1));

  // capture the accepted transaction and the geometry it runs under
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r     <= set_in;
      tag_r     <= tag_in;
      sh_r      <= sh_in;
      offs_r    <= off_eff;
      ways_ld_r <= ways_eff;
      act_r     <= in_action;
    end
  end

  assign meta_we    = cmd.clear || cmd.update;
  assign meta_waddr = cmd.clear ? clr_cnt_r : set_r;
  assign meta_wdata = cmd.clear ? '0 : meta_row_new;

  sact_ram #(.WIDTH(WAY_COUNT * TAG_W), .DEPTH(SET_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (set_r),
    .wdata (tag_row_new),
    .raddr (set_in),
    .rdata (tag_row)
  );

  sact_ram #(.WIDTH(WAY_COUNT * MW), .DEPTH(SET_COUNT)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (set_in),
    .rdata (meta_row)
  );

  // unpack the set rows
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      tag_a[w] = tag_row[w*TAG_W +: TAG_W];
      age_a[w] = meta_row[w*MW +: AGE_BITS];
      drt_a[w] = meta_row[w*MW + AGE_BITS];
      vld_a[w] = meta_row[w*MW + AGE_BITS + 1];
    end
  end

  // search for hit, lowest invalid way and oldest way
  always_comb begin
    hit_c   = 1'b0;
    inv_c   = 1'b0;
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (4'(w) < ways_ld_r) begin
        if (!hit_c && vld_a[w] && tag_a[w] == tag_r) begin
          hit_c   = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!inv_c && !vld_a[w]) begin
          inv_c   = 1'b1;
          inv_way = WAY_W'(w);
        end
        if (age_a[w] > age_a[old_way]) begin
          old_way = WAY_W'(w);
        end
      end
    end
    if (hit_c) begin
      victim = hit_way;
    end else if (inv_c) begin
      victim = inv_way;
    end else begin
      victim = old_way;
    end
  end

  // rebuild the victim line address and form the new rows
  always_comb begin
    wb_c      = !hit_c && vld_a[victim] && drt_a[victim];
    wb_addr_c = wb_c ? ((tag_a[victim] << sh_r) | (32'(set_r) << offs_r)) : 32'd0;
    tag_row_new  = tag_row;
    meta_row_new = meta_row;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (4'(w) < ways_ld_r) begin
        if (WAY_W'(w) == victim) begin
          meta_row_new[w*MW +: AGE_BITS]   = '0;
          meta_row_new[w*MW + AGE_BITS]    = hit_c ? (drt_a[w] | act_r) : act_r;
          meta_row_new[w*MW + AGE_BITS + 1] = 1'b1;
          if (!hit_c) begin
            tag_row_new[w*TAG_W +: TAG_W] = tag_r;
          end
        end else if (vld_a[w] && age_a[w] != AGE_MAX) begin
          meta_row_new[w*MW +: AGE_BITS] = age_a[w] + AGE_BITS'(1);
        end
      end
    end
  end

  // register the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r <= hit_c;
      out_way_r <= WAY_OUT_W'(victim);
      out_wb_r  <= wb_c;
      out_wba_r <= wb_addr_c;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = out_hit_r;
  assign out_way_used          = out_way_r;
  assign out_writeback         = out_wb_r;
  assign out_writeback_address = out_wba_r;

  `SACT_ASSERT_NEXT(a_strobe_src, cmd.update, out_valid_r, "result strobe missing")
  `SACT_ASSERT(a_wb_miss, !(out_valid_r && out_wb_r && out_hit_r), "write-back on a hit")

endmodule
`default_nettype wire

// ===== hw/rtl/set_assoc_cache_tag_lru_top.sv =====
// An accepted transaction is registered with its set's rows, then looked up,
// written back and its result registered in ST_LOOKUP, with busy high; no new
// one is taken until the tag and age rows are written through one RAM port
// pair. Reset: a clearing pass over every set zeroes the valid, dirty and age
// rows, with busy high; configuration writes are taken throughout.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_top
// Tag store of a set-associative write-back cache with age-counter LRU.
// ----------------------------------------------------------------------------
`default_nettype none
module set_assoc_cache_tag_lru_top #(
  parameter int SET_COUNT    = 256,
  parameter int WAY_COUNT    = 8,
  parameter int AGE_BITS     = 7,
  parameter int ADDRESS_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_action,
  input  wire logic [31:0]                    in_address,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [sact_pkg::WAY_OUT_W-1:0]      out_way_used,
  output logic                                out_writeback,
  output logic [31:0]                         out_writeback_address,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sact_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sact_pkg::CFG_W-1:0]     cfg_data
);
  import sact_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sact_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  sact_dp #(
    .SET_COUNT    (SET_COUNT),
    .WAY_COUNT    (WAY_COUNT),
    .AGE_BITS     (AGE_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_action             (in_action),
    .in_address            (in_address),
    .out_valid             (out_valid),
    .out_hit               (out_hit),
    .out_way_used          (out_way_used),
    .out_writeback         (out_writeback),
    .out_writeback_address (out_writeback_address)
  );

endmodule
`default_nettype wire
